>>> hw/rtl/hrp_pkg.sv
// Package for the HTTP request header parser: phase codes, verdict codes,
// character constants, match-pattern lookups and the result record.
// No dependencies; used by hrp_parser and the top level.
`default_nettype none

package hrp_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam logic [15:0] MAX_REQ_RESET = 16'd2048;

   // CSR map: one register, word index carried by paddr[2]
   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_IDX_MAX_REQ = 1'b0;

   typedef enum logic [3:0] {
      PH_METHOD   = 4'd0,
      PH_SP1      = 4'd1,
      PH_PREFIX   = 4'd2,
      PH_HOST     = 4'd3,
      PH_URL      = 4'd4,
      PH_SP2      = 4'd5,
      PH_VERSION  = 4'd6,
      PH_HDR_NAME = 4'd7,
      PH_CONN_VAL = 4'd8,
      PH_LEN_VAL  = 4'd9,
      PH_SKIP     = 4'd10,
      PH_BODY     = 4'd11
   } phase_type;

   localparam logic [1:0] VERDICT_DONE = 2'd0;
   localparam logic [1:0] VERDICT_BAD  = 2'd1;
   localparam logic [1:0] VERDICT_LONG = 2'd2;

   localparam logic KIND_URL     = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // length-value sub-states kept in the match position
   localparam logic [3:0] LEN_LEAD   = 4'd0;
   localparam logic [3:0] LEN_DIGITS = 4'd1;
   localparam logic [3:0] LEN_DONE   = 4'd2;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_H  = 8'h68;

   localparam logic [3:0] LEN_GET     = 4'd3;
   localparam logic [3:0] LEN_PREFIX  = 4'd7;
   localparam logic [3:0] LEN_VERSION = 4'd8;
   localparam logic [3:0] LEN_CONN    = 4'd11;
   localparam logic [3:0] LEN_CLEN    = 4'd15;
   localparam logic [3:0] LEN_KEEP    = 4'd10;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  url_byte;
      logic [1:0]  verdict;
      logic        keep_alive;
      logic [31:0] body_length;
   } result_type;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= CH_UP_A && b <= CH_UP_Z) ? b + 8'd32 : b;
   endfunction

   function automatic logic [7:0] get_char(input logic [3:0] p);
      case (p)
         4'd0: return 8'h67;   // g
         4'd1: return 8'h65;   // e
         4'd2: return 8'h74;   // t
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] prefix_char(input logic [3:0] p);
      case (p)
         4'd0: return 8'h68;   // h
         4'd1: return 8'h74;   // t
         4'd2: return 8'h74;   // t
         4'd3: return 8'h70;   // p
         4'd4: return 8'h3A;   // :
         4'd5: return 8'h2F;   // /
         4'd6: return 8'h2F;   // /
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] version_char(input logic [3:0] p);
      case (p)
         4'd0: return 8'h48;   // H
         4'd1: return 8'h54;   // T
         4'd2: return 8'h54;   // T
         4'd3: return 8'h50;   // P
         4'd4: return 8'h2F;   // /
         4'd5: return 8'h31;   // 1
         4'd6: return 8'h2E;   // .
         4'd7: return 8'h31;   // 1
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] conn_char(input logic [3:0] p);
      case (p)
         4'd0:  return 8'h63;  // c
         4'd1:  return 8'h6F;  // o
         4'd2:  return 8'h6E;  // n
         4'd3:  return 8'h6E;  // n
         4'd4:  return 8'h65;  // e
         4'd5:  return 8'h63;  // c
         4'd6:  return 8'h74;  // t
         4'd7:  return 8'h69;  // i
         4'd8:  return 8'h6F;  // o
         4'd9:  return 8'h6E;  // n
         4'd10: return 8'h3A;  // :
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] clen_char(input logic [3:0] p);
      case (p)
         4'd0:  return 8'h63;  // c
         4'd1:  return 8'h6F;  // o
         4'd2:  return 8'h6E;  // n
         4'd3:  return 8'h74;  // t
         4'd4:  return 8'h65;  // e
         4'd5:  return 8'h6E;  // n
         4'd6:  return 8'h74;  // t
         4'd7:  return 8'h2D;  // -
         4'd8:  return 8'h6C;  // l
         4'd9:  return 8'h65;  // e
         4'd10: return 8'h6E;  // n
         4'd11: return 8'h67;  // g
         4'd12: return 8'h74;  // t
         4'd13: return 8'h68;  // h
         4'd14: return 8'h3A;  // :
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] keep_char(input logic [3:0] p);
      case (p)
         4'd0: return 8'h6B;   // k
         4'd1: return 8'h65;   // e
         4'd2: return 8'h65;   // e
         4'd3: return 8'h70;   // p
         4'd4: return 8'h2D;   // -
         4'd5: return 8'h61;   // a
         4'd6: return 8'h6C;   // l
         4'd7: return 8'h69;   // i
         4'd8: return 8'h76;   // v
         4'd9: return 8'h65;   // e
         default: return 8'h00;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hrp_parser.sv
// Per-byte parse step: holds the parser state and produces at most one result
// (URL byte or verdict) per byte. Depends on hrp_pkg.
`default_nettype none

module hrp_parser #(
   parameter int COUNT_BITS = hrp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire logic [7:0]           item_byte,
   input  wire logic [15:0]          max_request_bytes,
   output hrp_pkg::result_type       result
);

   localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   hrp_pkg::phase_type     phase_ff, phase_in;
   logic [3:0]             pos_ff, pos_in;
   logic [1:0]             cand_ff, cand_in;
   logic                   vmatch_ff, vmatch_in;
   logic                   line_empty_ff, line_empty_in;
   logic                   pending_cr_ff, pending_cr_in;
   logic                   keep_ff, keep_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            decl_ff, decl_in;
   logic [31:0]            body_cnt_ff, body_cnt_in;
   logic [COUNT_BITS-1:0]  req_cnt_ff, req_cnt_in;

   logic [7:0]  lc;
   logic [3:0]  vpos;
   logic        is_digit;
   logic        c_conn, c_clen;
   logic [31:0] body_next;
   logic [35:0] acc_prod;
   logic [31:0] acc_sat;
   logic        hit;
   logic [1:0]  hit_code;

   assign lc        = hrp_pkg::to_lower(item_byte);
   assign is_digit  = (item_byte >= hrp_pkg::CH_ZERO) && (item_byte <= hrp_pkg::CH_NINE);
   assign body_next = body_cnt_ff + 32'd1;
   assign vpos      = (phase_ff == hrp_pkg::PH_SP2) ? 4'd0 : pos_ff;
   assign c_conn    = cand_ff[0] && (pos_ff < hrp_pkg::LEN_CONN)
                      && (lc == hrp_pkg::conn_char(pos_ff));
   assign c_clen    = cand_ff[1] && (pos_ff < hrp_pkg::LEN_CLEN)
                      && (lc == hrp_pkg::clen_char(pos_ff));
   // acc * 10 + digit, saturating at 32 bits
   assign acc_prod  = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                      + {32'd0, item_byte[3:0]};
   assign acc_sat   = (acc_prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_prod[31:0];

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      cand_in       = cand_ff;
      vmatch_in     = vmatch_ff;
      line_empty_in = line_empty_ff;
      pending_cr_in = pending_cr_ff;
      keep_in       = keep_ff;
      acc_in        = acc_ff;
      decl_in       = decl_ff;
      body_cnt_in   = body_cnt_ff;
      req_cnt_in    = req_cnt_ff;
      hit           = 1'b0;
      hit_code      = hrp_pkg::VERDICT_DONE;
      result        = '0;

      if (item_valid) begin
         if (CMP_BITS'(req_cnt_ff) >= CMP_BITS'(max_request_bytes)) begin
            hit      = 1'b1;
            hit_code = hrp_pkg::VERDICT_LONG;
         end else begin
            if (req_cnt_ff != '1) req_cnt_in = COUNT_BITS'(req_cnt_ff + 1'b1);

            if (phase_ff == hrp_pkg::PH_BODY) begin
               body_cnt_in = body_next;
               if (body_next >= decl_ff) hit = 1'b1;
            end else if (pending_cr_ff) begin
               pending_cr_in = 1'b0;
               if (item_byte != hrp_pkg::CH_LF) begin
                  hit      = 1'b1;
                  hit_code = hrp_pkg::VERDICT_BAD;
               end else begin
                  // line end: default is a fresh header line
                  phase_in      = hrp_pkg::PH_HDR_NAME;
                  pos_in        = 4'd0;
                  cand_in       = 2'b11;
                  vmatch_in     = 1'b1;
                  line_empty_in = 1'b1;
                  case (phase_ff)
                     hrp_pkg::PH_VERSION: begin
                        if (pos_ff != hrp_pkg::LEN_VERSION) begin
                           hit      = 1'b1;
                           hit_code = hrp_pkg::VERDICT_BAD;
                        end
                     end
                     hrp_pkg::PH_HDR_NAME: begin
                        if (line_empty_ff) begin
                           if (decl_ff == 32'd0) begin
                              hit = 1'b1;
                           end else begin
                              phase_in    = hrp_pkg::PH_BODY;
                              pos_in      = pos_ff;
                              cand_in     = cand_ff;
                              vmatch_in   = vmatch_ff;
                              line_empty_in = line_empty_ff;
                              body_cnt_in = 32'd0;
                           end
                        end
                     end
                     hrp_pkg::PH_CONN_VAL: begin
                        if (vmatch_ff && pos_ff == hrp_pkg::LEN_KEEP) keep_in = 1'b1;
                     end
                     hrp_pkg::PH_LEN_VAL: begin
                        decl_in = vmatch_ff ? acc_ff : 32'd0;
                     end
                     hrp_pkg::PH_SKIP: begin
                     end
                     default: begin
                        hit      = 1'b1;
                        hit_code = hrp_pkg::VERDICT_BAD;
                     end
                  endcase
               end
            end else if (item_byte == hrp_pkg::CH_CR) begin
               pending_cr_in = 1'b1;
            end else if (item_byte == hrp_pkg::CH_LF) begin
               hit      = 1'b1;
               hit_code = hrp_pkg::VERDICT_BAD;
            end else begin
               case (phase_ff)
                  hrp_pkg::PH_METHOD: begin
                     if (item_byte == hrp_pkg::CH_SP) begin
                        if (pos_ff != hrp_pkg::LEN_GET) begin
                           hit      = 1'b1;
                           hit_code = hrp_pkg::VERDICT_BAD;
                        end else begin
                           phase_in = hrp_pkg::PH_SP1;
                        end
                     end else if (pos_ff < hrp_pkg::LEN_GET
                                  && lc == hrp_pkg::get_char(pos_ff)) begin
                        pos_in = pos_ff + 4'd1;
                     end else begin
                        hit      = 1'b1;
                        hit_code = hrp_pkg::VERDICT_BAD;
                     end
                  end
                  hrp_pkg::PH_SP1: begin
                     if (item_byte == hrp_pkg::CH_SLASH) begin
                        phase_in        = hrp_pkg::PH_URL;
                        result.valid    = 1'b1;
                        result.url_byte = item_byte;
                     end else if (lc == hrp_pkg::CH_LO_H) begin
                        phase_in = hrp_pkg::PH_PREFIX;
                        pos_in   = 4'd1;
                     end else if (item_byte != hrp_pkg::CH_SP) begin
                        hit      = 1'b1;
                        hit_code = hrp_pkg::VERDICT_BAD;
                     end
                  end
                  hrp_pkg::PH_PREFIX: begin
                     if (pos_ff < hrp_pkg::LEN_PREFIX
                         && lc == hrp_pkg::prefix_char(pos_ff)) begin
                        pos_in = pos_ff + 4'd1;
                        if (pos_ff + 4'd1 == hrp_pkg::LEN_PREFIX) phase_in = hrp_pkg::PH_HOST;
                     end else begin
                        hit      = 1'b1;
                        hit_code = hrp_pkg::VERDICT_BAD;
                     end
                  end
                  hrp_pkg::PH_HOST: begin
                     if (item_byte == hrp_pkg::CH_SLASH) begin
                        phase_in        = hrp_pkg::PH_URL;
                        result.valid    = 1'b1;
                        result.url_byte = item_byte;
                     end
                  end
                  hrp_pkg::PH_URL: begin
                     if (item_byte == hrp_pkg::CH_SP) begin
                        phase_in = hrp_pkg::PH_SP2;
                     end else begin
                        result.valid    = 1'b1;
                        result.url_byte = item_byte;
                     end
                  end
                  hrp_pkg::PH_SP2, hrp_pkg::PH_VERSION: begin
                     if (!(phase_ff == hrp_pkg::PH_SP2 && item_byte == hrp_pkg::CH_SP)) begin
                        phase_in = hrp_pkg::PH_VERSION;
                        if (vpos < hrp_pkg::LEN_VERSION
                            && item_byte == hrp_pkg::version_char(vpos)) begin
                           pos_in = vpos + 4'd1;
                        end else begin
                           hit      = 1'b1;
                           hit_code = hrp_pkg::VERDICT_BAD;
                        end
                     end
                  end
                  hrp_pkg::PH_HDR_NAME: begin
                     line_empty_in = 1'b0;
                     cand_in       = {c_clen, c_conn};
                     if (!c_conn && !c_clen) begin
                        phase_in = hrp_pkg::PH_SKIP;
                     end else begin
                        pos_in = pos_ff + 4'd1;
                        if (c_conn && pos_ff + 4'd1 == hrp_pkg::LEN_CONN) begin
                           phase_in  = hrp_pkg::PH_CONN_VAL;
                           pos_in    = 4'd0;
                           vmatch_in = 1'b1;
                        end else if (c_clen && pos_ff + 4'd1 == hrp_pkg::LEN_CLEN) begin
                           phase_in  = hrp_pkg::PH_LEN_VAL;
                           pos_in    = 4'd0;
                           vmatch_in = 1'b1;
                           acc_in    = 32'd0;
                        end
                     end
                  end
                  hrp_pkg::PH_CONN_VAL: begin
                     if (!(pos_ff == 4'd0 && vmatch_ff && item_byte == hrp_pkg::CH_SP)) begin
                        if (vmatch_ff && pos_ff < hrp_pkg::LEN_KEEP
                            && lc == hrp_pkg::keep_char(pos_ff)) begin
                           pos_in = pos_ff + 4'd1;
                        end else begin
                           vmatch_in = 1'b0;
                        end
                     end
                  end
                  hrp_pkg::PH_LEN_VAL: begin
                     if (pos_ff == hrp_pkg::LEN_LEAD) begin
                        if (item_byte == hrp_pkg::CH_SP || item_byte == hrp_pkg::CH_TAB
                            || item_byte == hrp_pkg::CH_VT || item_byte == hrp_pkg::CH_FF) begin
                           pos_in = pos_ff;
                        end else if (item_byte == hrp_pkg::CH_MINUS) begin
                           vmatch_in = 1'b0;
                           pos_in    = hrp_pkg::LEN_DIGITS;
                        end else if (item_byte == hrp_pkg::CH_PLUS) begin
                           pos_in = hrp_pkg::LEN_DIGITS;
                        end else if (!is_digit) begin
                           pos_in = hrp_pkg::LEN_DONE;
                        end else begin
                           pos_in = hrp_pkg::LEN_DIGITS;
                           acc_in = acc_sat;
                        end
                     end else if (pos_ff == hrp_pkg::LEN_DIGITS) begin
                        if (is_digit) acc_in = acc_sat;
                        else          pos_in = hrp_pkg::LEN_DONE;
                     end
                  end
                  hrp_pkg::PH_SKIP: begin
                  end
                  default: begin
                     hit      = 1'b1;
                     hit_code = hrp_pkg::VERDICT_BAD;
                  end
               endcase
            end
         end

         if (hit) begin
            result.valid       = 1'b1;
            result.kind        = hrp_pkg::KIND_VERDICT;
            result.url_byte    = 8'd0;
            result.verdict     = hit_code;
            result.keep_alive  = keep_ff;
            result.body_length = decl_ff;
            // restart for the next request
            phase_in      = hrp_pkg::PH_METHOD;
            pos_in        = 4'd0;
            cand_in       = 2'b11;
            vmatch_in     = 1'b1;
            line_empty_in = 1'b1;
            pending_cr_in = 1'b0;
            keep_in       = 1'b0;
            acc_in        = 32'd0;
            decl_in       = 32'd0;
            body_cnt_in   = 32'd0;
            req_cnt_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hrp_pkg::PH_METHOD;
         pos_ff        <= 4'd0;
         cand_ff       <= 2'b11;
         vmatch_ff     <= 1'b1;
         line_empty_ff <= 1'b1;
         pending_cr_ff <= 1'b0;
         keep_ff       <= 1'b0;
         acc_ff        <= 32'd0;
         decl_ff       <= 32'd0;
         body_cnt_ff   <= 32'd0;
         req_cnt_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         cand_ff       <= cand_in;
         vmatch_ff     <= vmatch_in;
         line_empty_ff <= line_empty_in;
         pending_cr_ff <= pending_cr_in;
         keep_ff       <= keep_in;
         acc_ff        <= acc_in;
         decl_ff       <= decl_in;
         body_cnt_ff   <= body_cnt_in;
         req_cnt_ff    <= req_cnt_in;
      end
   end

   a_body_phase_has_length: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hrp_pkg::PH_BODY |-> decl_ff != 32'd0)
      else $error("body phase entered with zero declared length");

   a_verdict_restarts: assert property (@(posedge clock) disable iff (reset)
      item_valid && result.kind == hrp_pkg::KIND_VERDICT
      |=> phase_ff == hrp_pkg::PH_METHOD && req_cnt_ff == '0 && !keep_ff)
      else $error("parser state not restarted after verdict");

   a_cr_then_step: assert property (@(posedge clock) disable iff (reset)
      pending_cr_ff && item_valid |=> !pending_cr_ff)
      else $error("pending CR survived the next byte");

endmodule

`default_nettype wire

>>> hw/rtl/http_request_header_parser_core.sv
// HTTP request header parser top level: input register, CSR port, parse step
// and result register. Depends on hrp_pkg and hrp_parser.
//
// Usage:
//   req_* carries one received byte per transaction (valid/stall). rsp_* returns
//   zero or one result per byte: a URL byte (result_kind 0) or the final verdict
//   for the request (result_kind 1: done, bad, or too long), with keep_alive and
//   body_length. csr_* is an APB-style port holding max_request_bytes at
//   address 0 (reset 2048); write it only while no bytes are in flight.
//   A byte passes through the input register and then the result register
//   to reach rsp_*. Throughput: one byte per cycle while rsp_stall is low;
//   the input register, the parse step and the result register each hold one
//   byte or result. Reset clears the parser to the start of a request and
//   empties both registers. When rsp_stall is high and a result is held, the
//   input register keeps its byte and req_stall rises; nothing is dropped.
`default_nettype none

module http_request_header_parser_core #(
   parameter int COUNT_BITS = hrp_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_data_byte,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_result_kind,
   output logic [7:0]                              rsp_url_byte,
   output logic [1:0]                              rsp_verdict,
   output logic                                    rsp_keep_alive,
   output logic [31:0]                             rsp_body_length,

   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [hrp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic [15:0]          max_req_ff;
   logic                 out_free;
   logic                 req_accept;
   logic                 csr_hit;
   hrp_pkg::result_type  step_result;
   hrp_pkg::result_type  out_ff;

   // ---- CSR ----
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == hrp_pkg::CSR_IDX_MAX_REQ;
   assign csr_prdata = csr_hit ? {16'd0, max_req_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_req_ff <= hrp_pkg::MAX_REQ_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         max_req_ff <= csr_pwdata[15:0];
      end
   end

   // ---- input register ----
   assign out_free    = !out_ff.valid || !rsp_stall;
   assign req_stall   = in_valid_ff && !out_free;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept ? 1'b1 : (out_free ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) in_byte_ff <= req_data_byte;
   end

   // ---- parse step ----
   hrp_parser #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (in_valid_ff && out_free),
      .item_byte         (in_byte_ff),
      .max_request_bytes (max_req_ff),
      .result            (step_result)
   );

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (out_free) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid       = out_ff.valid;
   assign rsp_result_kind = out_ff.kind;
   assign rsp_url_byte    = out_ff.url_byte;
   assign rsp_verdict     = out_ff.verdict;
   assign rsp_keep_alive  = out_ff.keep_alive;
   assign rsp_body_length = out_ff.body_length;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held byte lost while result side stalled");

   a_url_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == hrp_pkg::KIND_URL
      |-> rsp_verdict == hrp_pkg::VERDICT_DONE && !rsp_keep_alive && rsp_body_length == 32'd0)
      else $error("URL result carries verdict fields");

   a_verdict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == hrp_pkg::KIND_VERDICT
      |-> rsp_url_byte == 8'd0 && rsp_verdict != 2'd3)
      else $error("verdict result malformed");

endmodule

`default_nettype wire
